FILE: rtl/dtau_pkg.sv
// ----------------------------------------------------------------------------
// dtau_pkg
// Shared types and constants for the dual antenna tag attribution unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dtau_pkg;

  // Default sizing
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int KEY_BITS_DEF    = 96;

  // Full tag identifier width on the ports
  localparam int EPC_BITS = 96;

  // Register reset values
  localparam logic signed [15:0] RSSI_FLOOR_RST      = -16'sd700;
  localparam logic        [15:0] RSSI_MARGIN_RST     = 16'd60;
  localparam logic        [7:0]  COUNT_DOMINANCE_RST = 8'd2;
  localparam logic        [15:0] MIN_READS_RST       = 16'd3;

  // Peak value of an antenna that has not seen the tag
  localparam logic signed [15:0] PEAK_UNSEEN = {1'b1, 15'd0};

  // Input item function
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_CLOSE = 1'b1;

  // Result verdicts
  typedef enum logic [2:0] {
    VERDICT_ATTRIBUTED  = 3'd0,
    VERDICT_BELOW_FLOOR = 3'd1,
    VERDICT_LOW_COUNT   = 3'd2,
    VERDICT_AMBIGUOUS   = 3'd3,
    VERDICT_EMPTY       = 3'd4
  } verdict_t;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_RSSI_FLOOR      = 2'd0,
    REG_RSSI_MARGIN     = 2'd1,
    REG_COUNT_DOMINANCE = 2'd2,
    REG_MIN_READS       = 2'd3
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_CLOSE_RD,
    ST_CLOSE_MUL,
    ST_CLOSE_JUDGE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/dual_antenna_tag_attribution_unit.sv
// ----------------------------------------------------------------------------
// dual_antenna_tag_attribution_unit
// Tracks tag reads from two antennas over a window and rates each tag on close.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken when start is high and busy is low.
//   func = read: the key is looked up in the key memory, one stored key per
//   cycle through its single read port, then the count/peak entry is read,
//   updated and written back. Busy stays high through the scan and, on a hit
//   or an insert, through the update. A new key with the table full is
//   dropped.
//   func = close: each entry, in insertion order, is read, passed through a
//   multiply stage and judged; a result is on the result ports for one
//   cycle with done high, in the cycle after its judge step. The
//   last result carries last = 1 and the table is emptied. An empty window
//   gives one result with verdict "empty" in the cycle after the transfer.
//   The receiver cannot stall: every result must be taken as it appears.
//   Reset clears the entry count and restores the thresholds; the memories
//   are not cleared, since only entries below the count are ever read.
//   Thresholds sit on an APB port at byte addresses 0, 4, 8 and 12; write
//   them only while busy is low and no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_antenna_tag_attribution_unit #(
  parameter int TABLE_DEPTH = dtau_pkg::TABLE_DEPTH_DEF,
  parameter int COUNT_BITS  = dtau_pkg::COUNT_BITS_DEF,
  parameter int KEY_BITS    = dtau_pkg::KEY_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               func,
  input  wire logic               antenna,
  input  wire logic signed [15:0] rssi,
  input  wire logic [31:0]        epc_high,
  input  wire logic [63:0]        epc_low,
  // result channel
  output logic                    done,
  output logic [31:0]             tag_high,
  output logic [63:0]             tag_low,
  output logic [2:0]              verdict,
  output logic                    winner,
  output logic signed [15:0]      peak_rssi,
  output logic [6:0]              entries_in_window,
  output logic                    last,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int DAT_W  = 2 * COUNT_BITS + 32;
  localparam int PROD_W = COUNT_BITS + 8;

  // Configuration registers
  logic signed [15:0] rssi_floor;
  logic [15:0]        rssi_margin;
  logic [7:0]         count_dominance;
  logic [15:0]        min_reads;

  // Control state
  dtau_pkg::state_t   state, state_next;
  logic [CNT_W-1:0]   entries_used;

  // Item registers
  logic [KEY_BITS-1:0] key_reg;
  logic                ant_reg;
  logic signed [15:0]  rssi_reg;
  logic [CNT_W-1:0]    scan_idx;
  logic                rd_pend;
  logic [IDX_W-1:0]    pend_idx;
  logic [IDX_W-1:0]    upd_idx;
  logic                fresh;
  logic [CNT_W-1:0]    walk_idx;

  // Memories: key per entry, {count0, count1, peak0, peak1} per entry
  logic [KEY_BITS-1:0] key_mem [TABLE_DEPTH];
  logic [DAT_W-1:0]    dat_mem [TABLE_DEPTH];
  logic [KEY_BITS-1:0] key_rd;
  logic [DAT_W-1:0]    dat_rd;
  logic [IDX_W-1:0]    key_raddr, dat_raddr;
  logic                key_we, dat_we;
  logic [DAT_W-1:0]    dat_wdata;

  // Judge pipeline registers
  logic [KEY_BITS-1:0] s_key;
  logic                s_win;
  logic [COUNT_BITS-1:0] s_cw, s_cl;
  logic signed [15:0]  s_pw, s_pl;
  logic [PROD_W-1:0]   s_prod;

  // Command decode
  logic [dtau_pkg::EPC_BITS-1:0] epc_all;
  logic [KEY_BITS-1:0] key_in;
  logic accept;
  logic key_match, scan_end, table_full;
  logic [CNT_W-1:0] walk_inc;
  logic walk_last;

  assign busy       = (state != dtau_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign epc_all    = {epc_high, epc_low};
  assign key_in     = epc_all[KEY_BITS-1:0];
  assign key_match  = rd_pend && (key_rd == key_reg);
  assign scan_end   = (scan_idx == entries_used);
  assign table_full = (entries_used == CNT_W'(TABLE_DEPTH));
  assign walk_inc   = walk_idx + 1'b1;
  assign walk_last  = (walk_inc == entries_used);

  // Next state and memory control
  always_comb begin
    state_next = state;
    key_raddr  = scan_idx[IDX_W-1:0];
    dat_raddr  = pend_idx;
    key_we     = 1'b0;
    dat_we     = 1'b0;
    unique case (state)
      dtau_pkg::ST_IDLE: begin
        if (accept) begin
          if (func == dtau_pkg::FUNC_READ) begin
            state_next = dtau_pkg::ST_SCAN;
          end else if (entries_used != '0) begin
            state_next = dtau_pkg::ST_CLOSE_RD;
          end
        end
      end
      dtau_pkg::ST_SCAN: begin
        if (key_match) begin
          state_next = dtau_pkg::ST_UPDATE;
        end else if (scan_end) begin
          if (table_full) begin
            state_next = dtau_pkg::ST_IDLE;
          end else begin
            key_we     = 1'b1;
            state_next = dtau_pkg::ST_UPDATE;
          end
        end
      end
      dtau_pkg::ST_UPDATE: begin
        dat_we     = 1'b1;
        state_next = dtau_pkg::ST_IDLE;
      end
      dtau_pkg::ST_CLOSE_RD: begin
        key_raddr  = walk_idx[IDX_W-1:0];
        dat_raddr  = walk_idx[IDX_W-1:0];
        state_next = dtau_pkg::ST_CLOSE_MUL;
      end
      dtau_pkg::ST_CLOSE_MUL: begin
        state_next = dtau_pkg::ST_CLOSE_JUDGE;
      end
      dtau_pkg::ST_CLOSE_JUDGE: begin
        state_next = walk_last ? dtau_pkg::ST_IDLE : dtau_pkg::ST_CLOSE_RD;
      end
      default: begin
        state_next = dtau_pkg::ST_IDLE;
      end
    endcase
  end

  // Entry update: saturating count, running peak
  logic [COUNT_BITS-1:0] cur_c0, cur_c1, new_c0, new_c1;
  logic signed [15:0]    cur_p0, cur_p1, new_p0, new_p1;

  always_comb begin
    if (fresh) begin
      cur_c0 = '0;
      cur_c1 = '0;
      cur_p0 = dtau_pkg::PEAK_UNSEEN;
      cur_p1 = dtau_pkg::PEAK_UNSEEN;
    end else begin
      cur_c0 = dat_rd[DAT_W-1 -: COUNT_BITS];
      cur_c1 = dat_rd[DAT_W-COUNT_BITS-1 -: COUNT_BITS];
      cur_p0 = dat_rd[31:16];
      cur_p1 = dat_rd[15:0];
    end
    new_c0 = cur_c0;
    new_c1 = cur_c1;
    new_p0 = cur_p0;
    new_p1 = cur_p1;
    if (ant_reg == 1'b0) begin
      if (!(&cur_c0)) new_c0 = cur_c0 + 1'b1;
      if (rssi_reg > cur_p0) new_p0 = rssi_reg;
    end else begin
      if (!(&cur_c1)) new_c1 = cur_c1 + 1'b1;
      if (rssi_reg > cur_p1) new_p1 = rssi_reg;
    end
    dat_wdata = {new_c0, new_c1, new_p0, new_p1};
  end

  // Memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (key_we) key_mem[entries_used[IDX_W-1:0]] <= key_reg;
    key_rd <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (dat_we) dat_mem[upd_idx] <= dat_wdata;
    dat_rd <= dat_mem[dat_raddr];
  end

  // Winner select on the entry just read
  logic [COUNT_BITS-1:0] rd_c0, rd_c1;
  logic signed [15:0]    rd_p0, rd_p1;
  logic                  rd_win;

  assign rd_c0  = dat_rd[DAT_W-1 -: COUNT_BITS];
  assign rd_c1  = dat_rd[DAT_W-COUNT_BITS-1 -: COUNT_BITS];
  assign rd_p0  = dat_rd[31:16];
  assign rd_p1  = dat_rd[15:0];
  assign rd_win = (rd_p0 >= rd_p1) ? 1'b0 : 1'b1;

  // Verdict on the registered stage
  logic signed [17:0] pdiff, margin_ext;
  dtau_pkg::verdict_t judge_v;

  assign pdiff      = {{2{s_pw[15]}}, s_pw} - {{2{s_pl[15]}}, s_pl};
  assign margin_ext = {2'b00, rssi_margin};

  always_comb begin
    priority if (32'(s_cw) < 32'(min_reads)) begin
      judge_v = dtau_pkg::VERDICT_LOW_COUNT;
    end else if (s_pw < rssi_floor) begin
      judge_v = dtau_pkg::VERDICT_BELOW_FLOOR;
    end else if (s_cl == '0) begin
      judge_v = dtau_pkg::VERDICT_ATTRIBUTED;
    end else if (pdiff < margin_ext) begin
      judge_v = dtau_pkg::VERDICT_AMBIGUOUS;
    end else if (PROD_W'(s_cw) < s_prod) begin
      judge_v = dtau_pkg::VERDICT_AMBIGUOUS;
    end else begin
      judge_v = dtau_pkg::VERDICT_ATTRIBUTED;
    end
  end

  logic [dtau_pkg::EPC_BITS-1:0] s_tag;
  assign s_tag = dtau_pkg::EPC_BITS'(s_key);

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= dtau_pkg::ST_IDLE;
      entries_used    <= '0;
      done            <= 1'b0;
      rssi_floor      <= dtau_pkg::RSSI_FLOOR_RST;
      rssi_margin     <= dtau_pkg::RSSI_MARGIN_RST;
      count_dominance <= dtau_pkg::COUNT_DOMINANCE_RST;
      min_reads       <= dtau_pkg::MIN_READS_RST;
    end else begin
      state <= state_next;
      // result strobe: empty window on its transfer, else after each judge step
      done  <= (state == dtau_pkg::ST_CLOSE_JUDGE) ||
               (state == dtau_pkg::ST_IDLE && accept && func == dtau_pkg::FUNC_CLOSE
                && entries_used == '0);
      if (state == dtau_pkg::ST_SCAN && !key_match && scan_end && !table_full) begin
        entries_used <= entries_used + 1'b1;
      end
      if (state == dtau_pkg::ST_CLOSE_JUDGE && walk_last) begin
        entries_used <= '0;
      end
      // register write transfer
      if (psel && penable && pwrite && pready) begin
        unique case (dtau_pkg::reg_idx_t'(paddr[3:2]))
          dtau_pkg::REG_RSSI_FLOOR:      rssi_floor      <= pwdata[15:0];
          dtau_pkg::REG_RSSI_MARGIN:     rssi_margin     <= pwdata[15:0];
          dtau_pkg::REG_COUNT_DOMINANCE: count_dominance <= pwdata[7:0];
          dtau_pkg::REG_MIN_READS:       min_reads       <= pwdata[15:0];
        endcase
      end
    end
  end

  // Item, pipeline and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      dtau_pkg::ST_IDLE: begin
        if (accept) begin
          key_reg  <= key_in;
          ant_reg  <= antenna;
          rssi_reg <= rssi;
          scan_idx <= '0;
          rd_pend  <= 1'b0;
          walk_idx <= '0;
          // empty window
          tag_high          <= '0;
          tag_low           <= '0;
          verdict           <= dtau_pkg::VERDICT_EMPTY;
          winner            <= 1'b0;
          peak_rssi         <= '0;
          entries_in_window <= '0;
          last              <= 1'b1;
        end
      end
      dtau_pkg::ST_SCAN: begin
        if (key_match) begin
          upd_idx <= pend_idx;
          fresh   <= 1'b0;
        end else if (scan_end) begin
          upd_idx <= entries_used[IDX_W-1:0];
          fresh   <= 1'b1;
        end else begin
          rd_pend  <= 1'b1;
          pend_idx <= scan_idx[IDX_W-1:0];
          scan_idx <= scan_idx + 1'b1;
        end
      end
      dtau_pkg::ST_CLOSE_MUL: begin
        s_key  <= key_rd;
        s_win  <= rd_win;
        s_cw   <= rd_win ? rd_c1 : rd_c0;
        s_cl   <= rd_win ? rd_c0 : rd_c1;
        s_pw   <= rd_win ? rd_p1 : rd_p0;
        s_pl   <= rd_win ? rd_p0 : rd_p1;
        s_prod <= PROD_W'(count_dominance) * PROD_W'(rd_win ? rd_c0 : rd_c1);
      end
      dtau_pkg::ST_CLOSE_JUDGE: begin
        tag_high          <= s_tag[95:64];
        tag_low           <= s_tag[63:0];
        verdict           <= judge_v;
        winner            <= s_win;
        peak_rssi         <= s_pw;
        entries_in_window <= 7'(entries_used);
        last              <= walk_last;
        walk_idx          <= walk_inc;
      end
      default: begin
      end
    endcase
  end

  // Register read-back
  always_comb begin
    unique case (dtau_pkg::reg_idx_t'(paddr[3:2]))
      dtau_pkg::REG_RSSI_FLOOR:      prdata = 32'(rssi_floor);
      dtau_pkg::REG_RSSI_MARGIN:     prdata = {16'd0, rssi_margin};
      dtau_pkg::REG_COUNT_DOMINANCE: prdata = {24'd0, count_dominance};
      dtau_pkg::REG_MIN_READS:       prdata = {16'd0, min_reads};
    endcase
  end

  assign pready = 1'b1;

endmodule

`default_nettype wire
